[design/ffe_pkg.sv]
package ffe_pkg;

  localparam int WordW    = 32;
  localparam int FracW    = 16;
  localparam int CfgW     = 31;
  localparam int RegIdxW  = 3;
  // restoring divider: one quotient bit per stage
  localparam int DivSteps = WordW;
  // prep + DivSteps iterations + sign/saturate + nine flux stages
  localparam int FluxLat  = DivSteps + 11;

  localparam logic [RegIdxW-1:0] RegGamma = 3'd0;
  localparam logic [RegIdxW-1:0] RegDtDx  = 3'd1;
  localparam logic [RegIdxW-1:0] RegDxDt  = 3'd2;
  localparam logic [RegIdxW-1:0] RegDtDy  = 3'd3;
  localparam logic [RegIdxW-1:0] RegDyDt  = 3'd4;

  localparam logic [CfgW-1:0] GammaReset = 31'd26214;

  // conserved-variable slots
  localparam int IRho = 0;
  localparam int IMx  = 1;
  localparam int IMy  = 2;
  localparam int IEn  = 3;

  typedef logic signed [WordW-1:0]   word_t;
  typedef logic signed [2*WordW-1:0] prod_t;
  typedef logic signed [2*WordW+1:0] wide_t;
  typedef word_t quad_t [4];

  localparam word_t WordMax = word_t'({1'b0, {(WordW-1){1'b1}}});
  localparam word_t WordMin = word_t'({1'b1, {(WordW-1){1'b0}}});

  typedef struct packed {
    logic              req_type;
    logic [CfgW-1:0]   left_density;
    logic signed [WordW-1:0] left_mom_x;
    logic signed [WordW-1:0] left_mom_y;
    logic [CfgW-1:0]   left_energy;
    logic [CfgW-1:0]   right_density;
    logic signed [WordW-1:0] right_mom_x;
    logic signed [WordW-1:0] right_mom_y;
    logic [CfgW-1:0]   right_energy;
  } in_word_t;

  typedef struct packed {
    logic signed [WordW-1:0] flux_mass;
    logic signed [WordW-1:0] flux_mom_x;
    logic signed [WordW-1:0] flux_mom_y;
    logic signed [WordW-1:0] flux_energy;
    logic                    bad_density;
  } out_word_t;

  function automatic word_t sat_w(input wide_t v);
    if (v > WordMax) return WordMax;
    else if (v < WordMin) return WordMin;
    else return word_t'(v[WordW-1:0]);
  endfunction

  // Q16.16 product: floor shift, then clamp
  function automatic word_t qprod(input prod_t p);
    return sat_w(wide_t'(p >>> FracW));
  endfunction

  function automatic word_t qadd(input word_t a, input word_t b);
    logic signed [WordW:0] s;
    s = a + b;
    return sat_w(wide_t'(s));
  endfunction

  function automatic word_t qsub(input word_t a, input word_t b);
    logic signed [WordW:0] s;
    s = a - b;
    return sat_w(wide_t'(s));
  endfunction

  function automatic word_t hsum(input word_t a, input word_t b);
    logic signed [WordW:0] s;
    s = a + b;
    return sat_w(wide_t'(s >>> 1));
  endfunction

  function automatic word_t hdiff(input word_t a, input word_t b);
    logic signed [WordW:0] s;
    s = a - b;
    return sat_w(wide_t'(s >>> 1));
  endfunction

  function automatic word_t cfg2w(input logic [CfgW-1:0] c);
    return word_t'({1'b0, c});
  endfunction

endpackage

[design/ffe_flux.sv]
// Directional Euler flux of one state. Velocities by two pipelined dividers,
// then nine multiply/saturate stages.
module ffe_flux import ffe_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  v_i,
  input  logic  along_y_i,
  input  quad_t u_i,
  input  word_t g1_i,
  output logic  v_o,
  output quad_t f_o
);

  localparam int Fin = DivSteps + 1;
  localparam int S2  = Fin + 2;
  localparam int S4  = Fin + 4;
  localparam int S6  = Fin + 6;
  localparam int S8  = Fin + 8;

  typedef struct packed {
    logic [WordW-1:0] rem;
    logic [WordW-1:0] num;
    logic [WordW-1:0] quo;
    logic             neg;
    logic             ovf;
    logic             zero;
  } div_t;

  function automatic div_t div_prep(input word_t a, input word_t b);
    logic [WordW-1:0] mag;
    div_t d;
    mag    = a[WordW-1] ? -a : a;
    d.rem  = {{FracW{1'b0}}, mag[WordW-1:FracW]};
    d.num  = {mag[FracW-1:0], {FracW{1'b0}}};
    d.quo  = '0;
    d.neg  = a[WordW-1];
    d.zero = b[WordW-1] || (b == '0);
    // quotient would need more than WordW bits
    d.ovf  = (d.rem >= $unsigned(b));
    return d;
  endfunction

  function automatic div_t div_step(input div_t d, input word_t b);
    logic [WordW-1:0] t;
    div_t n;
    n = d;
    t = {d.rem[WordW-2:0], d.num[WordW-1]};
    n.num = {d.num[WordW-2:0], 1'b0};
    if (t >= $unsigned(b)) begin
      n.rem = t - $unsigned(b);
      n.quo = {d.quo[WordW-2:0], 1'b1};
    end else begin
      n.rem = t;
      n.quo = {d.quo[WordW-2:0], 1'b0};
    end
    return n;
  endfunction

  function automatic word_t div_fin(input div_t d);
    if (d.zero) return '0;
    else if (d.neg) begin
      if (d.ovf || (d.quo > {1'b1, {(WordW-1){1'b0}}})) return WordMin;
      else return word_t'(-d.quo);
    end else begin
      if (d.ovf || d.quo[WordW-1]) return WordMax;
      else return word_t'(d.quo);
    end
  endfunction

  logic [FluxLat-1:0] v_q;
  logic [FluxLat-1:0] ay_q;
  quad_t c_q [FluxLat];
  div_t  dx_q [DivSteps+1];
  div_t  dy_q [DivSteps+1];

  word_t vx_q, vy_q;
  prod_t pxx_q, pyy_q, prn_q;
  word_t s1_vx_q, s1_vy_q;
  word_t v2_q, rvn_q, s2_vx_q, s2_vy_q;
  prod_t prv2_q, pf1_q, pf2_q;
  word_t s3_vn_q;
  word_t t_q, f1p_q, f2p_q, s4_vn_q;
  word_t d_q, s5_f1p_q, s5_f2p_q, s5_vn_q;
  prod_t pg_q;
  word_t s6_f1p_q, s6_f2p_q, s6_vn_q;
  word_t f1_q, f2_q, ep_q, s7_vn_q;
  prod_t pe_q;
  word_t s8_f1_q, s8_f2_q;
  quad_t f_q;

  word_t vn_s1, p_s7;

  always_comb begin
    vn_s1 = ay_q[Fin] ? vy_q : vx_q;
    p_s7  = qprod(pg_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[FluxLat-2:0], v_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q[0]  <= u_i;
      ay_q    <= {ay_q[FluxLat-2:0], along_y_i};
      for (int k = 1; k < FluxLat; k++) c_q[k] <= c_q[k-1];

      dx_q[0] <= div_prep(u_i[IMx], u_i[IRho]);
      dy_q[0] <= div_prep(u_i[IMy], u_i[IRho]);
      for (int k = 1; k <= DivSteps; k++) begin
        dx_q[k] <= div_step(dx_q[k-1], c_q[k-1][IRho]);
        dy_q[k] <= div_step(dy_q[k-1], c_q[k-1][IRho]);
      end
      vx_q <= div_fin(dx_q[DivSteps]);
      vy_q <= div_fin(dy_q[DivSteps]);

      // S1
      pxx_q   <= vx_q * vx_q;
      pyy_q   <= vy_q * vy_q;
      prn_q   <= c_q[Fin][IRho] * vn_s1;
      s1_vx_q <= vx_q;
      s1_vy_q <= vy_q;
      // S2
      v2_q    <= qadd(qprod(pxx_q), qprod(pyy_q));
      rvn_q   <= qprod(prn_q);
      s2_vx_q <= s1_vx_q;
      s2_vy_q <= s1_vy_q;
      // S3
      prv2_q  <= c_q[S2][IRho] * v2_q;
      pf1_q   <= rvn_q * s2_vx_q;
      pf2_q   <= rvn_q * s2_vy_q;
      s3_vn_q <= ay_q[S2] ? s2_vy_q : s2_vx_q;
      // S4
      t_q     <= qprod(prv2_q);
      f1p_q   <= qprod(pf1_q);
      f2p_q   <= qprod(pf2_q);
      s4_vn_q <= s3_vn_q;
      // S5: kinetic energy is half of rho*v^2
      d_q      <= qsub(c_q[S4][IEn], t_q >>> 1);
      s5_f1p_q <= f1p_q;
      s5_f2p_q <= f2p_q;
      s5_vn_q  <= s4_vn_q;
      // S6
      pg_q     <= g1_i * d_q;
      s6_f1p_q <= s5_f1p_q;
      s6_f2p_q <= s5_f2p_q;
      s6_vn_q  <= s5_vn_q;
      // S7: pressure joins the normal momentum flux
      f1_q    <= ay_q[S6] ? s6_f1p_q : qadd(s6_f1p_q, p_s7);
      f2_q    <= ay_q[S6] ? qadd(s6_f2p_q, p_s7) : s6_f2p_q;
      ep_q    <= qadd(c_q[S6][IEn], p_s7);
      s7_vn_q <= s6_vn_q;
      // S8
      pe_q    <= ep_q * s7_vn_q;
      s8_f1_q <= f1_q;
      s8_f2_q <= f2_q;
      // S9
      f_q[IRho] <= ay_q[S8] ? c_q[S8][IMy] : c_q[S8][IMx];
      f_q[IMx]  <= s8_f1_q;
      f_q[IMy]  <= s8_f2_q;
      f_q[IEn]  <= qprod(pe_q);
    end
  end

  assign v_o = v_q[FluxLat-1];
  assign f_o = f_q;

endmodule

[design/force_flux_euler_2d.sv]
// FORCE interface flux, 2D Euler, ideal gas, signed Q16.16.
//
// Input channel (in_valid_i/in_ready_o/in_i): one word holds both cell
// states and the direction bit. Output channel (out_valid_o/out_ready_i/
// out_o): one flux word per input word, in order.
// Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 gamma-1,
// 1 dt/dx, 2 dx/dt, 3 dt/dy, 4 dy/dt); other indexes are dropped. Write
// only while no word is in flight.
//
// Throughput: one word per cycle while the skid is empty. The input
// register loads at the accepting edge; then come two passes through
// the flux unit (43 stages each, 32 of them the one-bit-per-stage
// velocity dividers) and five stages of averaging and output registers.
// Reset: empties the pipe, loads config reset values; ready right away.
// Stall: the pipe moves as one; a skid register catches the word that
// leaves while the output is held, and in_ready_o drops only while the
// skid is full. Nothing is lost or repeated.
module force_flux_euler_2d import ffe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [RegIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_word_t           in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_word_t          out_o
);

  // config registers
  logic [CfgW-1:0] gamma_q, dtdx_q, dxdt_q, dtdy_q, dydt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gamma_q <= GammaReset;
      dtdx_q  <= '0;
      dxdt_q  <= '0;
      dtdy_q  <= '0;
      dydt_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegGamma: gamma_q <= cfg_data_i;
        RegDtDx:  dtdx_q  <= cfg_data_i;
        RegDxDt:  dxdt_q  <= cfg_data_i;
        RegDtDy:  dtdy_q  <= cfg_data_i;
        RegDyDt:  dydt_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic adv;          // whole pipe advances
  logic skid_v_q, out_v_q;
  out_word_t skid_q, out_q;

  assign adv        = !skid_v_q;
  assign in_ready_o = adv;

  // stage 0: register the input word
  logic  s0_v_q, s0_ay_q, s0_bad_q;
  quad_t s0_lu_q, s0_ru_q;

  // first flux pass
  logic  fl_v, fr_v;
  quad_t fl, fr;
  quad_t sd_lu_q [FluxLat];
  quad_t sd_ru_q [FluxLat];
  logic [FluxLat-1:0] sd_ay_q, sd_bad_q;

  // averaging stages
  logic  h1_v_q, h1_ay_q, h1_bad_q;
  quad_t h1_hd_q, h1_hs_q, h1_hdu_q, h1_hsf_q;
  logic  h2_v_q, h2_bad_q;
  prod_t h2_pr_q [4];
  prod_t h2_ps_q [4];
  quad_t h2_hs_q, h2_hsf_q;
  logic  h3_v_q, h3_ay_q, h3_bad_q;
  quad_t h3_uh_q, h3_lf_q;

  // half-step flux pass
  logic  fh_v;
  quad_t fh;
  quad_t sd2_lf_q [FluxLat];
  logic [FluxLat-1:0] sd2_bad_q;

  logic  f_v_q, f_bad_q;
  quad_t f_res_q;

  word_t r_sel, s_sel;
  quad_t uh_d, lf_d;
  logic  bad1_d;

  always_comb begin
    r_sel = h1_ay_q ? cfg2w(dtdy_q) : cfg2w(dtdx_q);
    s_sel = h1_ay_q ? cfg2w(dydt_q) : cfg2w(dxdt_q);
    for (int i = 0; i < 4; i++) begin
      uh_d[i] = qsub(h2_hs_q[i], qprod(h2_pr_q[i]));
      lf_d[i] = qadd(qprod(h2_ps_q[i]), h2_hsf_q[i]);
    end
    bad1_d = h2_bad_q || (uh_d[IRho] <= 0);
  end

  // direction carried on to the half-step flux pass
  logic h2_ay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      h1_v_q <= 1'b0;
      h2_v_q <= 1'b0;
      h3_v_q <= 1'b0;
      f_v_q  <= 1'b0;
    end else if (adv) begin
      s0_v_q <= in_valid_i;
      h1_v_q <= fl_v;
      h2_v_q <= h1_v_q;
      h3_v_q <= h2_v_q;
      f_v_q  <= fh_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_ay_q       <= in_i.req_type;
      s0_lu_q[IRho] <= cfg2w(in_i.left_density);
      s0_lu_q[IMx]  <= in_i.left_mom_x;
      s0_lu_q[IMy]  <= in_i.left_mom_y;
      s0_lu_q[IEn]  <= cfg2w(in_i.left_energy);
      s0_ru_q[IRho] <= cfg2w(in_i.right_density);
      s0_ru_q[IMx]  <= in_i.right_mom_x;
      s0_ru_q[IMy]  <= in_i.right_mom_y;
      s0_ru_q[IEn]  <= cfg2w(in_i.right_energy);
      s0_bad_q      <= (in_i.left_density == '0) || (in_i.right_density == '0);

      sd_lu_q[0] <= s0_lu_q;
      sd_ru_q[0] <= s0_ru_q;
      sd_ay_q    <= {sd_ay_q[FluxLat-2:0], s0_ay_q};
      sd_bad_q   <= {sd_bad_q[FluxLat-2:0], s0_bad_q};
      for (int k = 1; k < FluxLat; k++) begin
        sd_lu_q[k] <= sd_lu_q[k-1];
        sd_ru_q[k] <= sd_ru_q[k-1];
      end

      for (int i = 0; i < 4; i++) begin
        h1_hd_q[i]  <= hdiff(fr[i], fl[i]);
        h1_hs_q[i]  <= hsum(sd_lu_q[FluxLat-1][i], sd_ru_q[FluxLat-1][i]);
        h1_hdu_q[i] <= hdiff(sd_lu_q[FluxLat-1][i], sd_ru_q[FluxLat-1][i]);
        h1_hsf_q[i] <= hsum(fl[i], fr[i]);
      end
      h1_ay_q  <= sd_ay_q[FluxLat-1];
      h1_bad_q <= sd_bad_q[FluxLat-1];

      for (int i = 0; i < 4; i++) begin
        h2_pr_q[i] <= r_sel * h1_hd_q[i];
        h2_ps_q[i] <= s_sel * h1_hdu_q[i];
      end
      h2_hs_q  <= h1_hs_q;
      h2_hsf_q <= h1_hsf_q;
      h2_ay_q  <= h1_ay_q;
      h2_bad_q <= h1_bad_q;

      h3_uh_q  <= uh_d;
      h3_lf_q  <= lf_d;
      h3_ay_q  <= h2_ay_q;
      h3_bad_q <= bad1_d;

      sd2_lf_q[0] <= h3_lf_q;
      sd2_bad_q   <= {sd2_bad_q[FluxLat-2:0], h3_bad_q};
      for (int k = 1; k < FluxLat; k++) sd2_lf_q[k] <= sd2_lf_q[k-1];

      for (int i = 0; i < 4; i++) begin
        f_res_q[i] <= sd2_bad_q[FluxLat-1] ? '0 : hsum(sd2_lf_q[FluxLat-1][i], fh[i]);
      end
      f_bad_q <= sd2_bad_q[FluxLat-1];
    end
  end

  ffe_flux u_flux_l (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .v_i       (s0_v_q),
    .along_y_i (s0_ay_q),
    .u_i       (s0_lu_q),
    .g1_i      (cfg2w(gamma_q)),
    .v_o       (fl_v),
    .f_o       (fl)
  );

  ffe_flux u_flux_r (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .v_i       (s0_v_q),
    .along_y_i (s0_ay_q),
    .u_i       (s0_ru_q),
    .g1_i      (cfg2w(gamma_q)),
    .v_o       (fr_v),
    .f_o       (fr)
  );

  ffe_flux u_flux_h (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (adv),
    .v_i       (h3_v_q),
    .along_y_i (h3_ay_q),
    .u_i       (h3_uh_q),
    .g1_i      (cfg2w(gamma_q)),
    .v_o       (fh_v),
    .f_o       (fh)
  );

  // output register plus skid
  out_word_t res_w;
  logic      arrive, take;

  always_comb begin
    res_w.flux_mass   = f_res_q[IRho];
    res_w.flux_mom_x  = f_res_q[IMx];
    res_w.flux_mom_y  = f_res_q[IMy];
    res_w.flux_energy = f_res_q[IEn];
    res_w.bad_density = f_bad_q;
    arrive = adv && f_v_q;
    take   = out_ready_i || !out_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q  <= arrive;
      end
    end else if (arrive) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= skid_v_q ? skid_q : res_w;
    end else if (arrive) begin
      skid_q <= res_w;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  // the two first-pass flux units run in lockstep
  a_lr_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fl_v == fr_v) else $error("left/right flux valid mismatch");

  a_skid_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q) else $error("skid full without output word");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && out_ready_i |=> !skid_v_q) else $error("skid did not drain");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.bad_density |-> out_q.flux_mass == 0 && out_q.flux_mom_x == 0
      && out_q.flux_mom_y == 0 && out_q.flux_energy == 0)
    else $error("bad density word carries nonzero flux");

endmodule

[tb/tb_force_flux_euler_2d.sv]
module tb_force_flux_euler_2d;
  import ffe_pkg::*;

  // Settle time is scaled from the pipe latency.
  localparam int PipeLat  = 91;
  localparam int Settle   = 2 * PipeLat;
  localparam int StallMax = 20000;
  localparam int NumRand  = 1750;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  in_word_t           in_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  out_word_t          out_o;

  force_flux_euler_2d dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --- flux predictor, 64-bit signed math, clamps to the word range ---
  typedef longint signed q4_t [4];

  longint signed gam_q, dtdx_q, dxdt_q, dtdy_q, dydt_q;

  function automatic longint signed clamp(longint signed v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // arithmetic shift gives floor rounding
  function automatic longint signed fmul(longint signed a, longint signed b);
    return clamp((a * b) >>> 16);
  endfunction

  function automatic longint signed fadd(longint signed a, longint signed b);
    return clamp(a + b);
  endfunction

  function automatic longint signed hs(longint signed a, longint signed b);
    return clamp((a + b) >>> 1);
  endfunction

  function automatic longint signed hd(longint signed a, longint signed b);
    return clamp((a - b) >>> 1);
  endfunction

  // quotient truncates toward zero; non-positive divisor yields zero
  function automatic longint signed fdiv(longint signed a, longint signed b);
    if (b <= 0) return 0;
    return clamp((a * 65536) / b);
  endfunction

  function automatic q4_t dir_flux(q4_t u, bit along_y);
    q4_t f;
    longint signed vx, vy, v2, ke, pr, vn, rvn;
    vx  = fdiv(u[1], u[0]);
    vy  = fdiv(u[2], u[0]);
    v2  = fadd(fmul(vx, vx), fmul(vy, vy));
    ke  = fmul(32768, fmul(u[0], v2));
    pr  = fmul(gam_q, clamp(u[3] - ke));
    vn  = along_y ? vy : vx;
    rvn = fmul(u[0], vn);
    f[0] = along_y ? u[2] : u[1];
    f[1] = fmul(rvn, vx);
    f[2] = fmul(rvn, vy);
    if (along_y) f[2] = fadd(f[2], pr);
    else f[1] = fadd(f[1], pr);
    f[3] = fmul(fadd(u[3], pr), vn);
    return f;
  endfunction

  function automatic out_word_t model_flux(in_word_t w);
    out_word_t o;
    q4_t lu, ru, fl, fr, uh, fh;
    longint signed r, s, lf;
    bit along_y, bad;
    along_y = w.req_type;
    r = along_y ? dtdy_q : dtdx_q;
    s = along_y ? dydt_q : dxdt_q;
    lu = '{longint'(w.left_density), longint'(w.left_mom_x),
           longint'(w.left_mom_y), longint'(w.left_energy)};
    ru = '{longint'(w.right_density), longint'(w.right_mom_x),
           longint'(w.right_mom_y), longint'(w.right_energy)};
    o = '0;
    bad = lu[0] <= 0 || ru[0] <= 0;
    if (!bad) begin
      fl = dir_flux(lu, along_y);
      fr = dir_flux(ru, along_y);
      for (int i = 0; i < 4; i++)
        uh[i] = clamp(hs(lu[i], ru[i]) - fmul(r, hd(fr[i], fl[i])));
      bad = uh[0] <= 0;
      if (!bad) begin
        fh = dir_flux(uh, along_y);
        for (int i = 0; i < 4; i++) begin
          lf = fadd(fmul(s, hd(lu[i], ru[i])), hs(fl[i], fr[i]));
          lf = hs(lf, fh[i]);
          case (i)
            IRho: o.flux_mass   = word_t'(lf);
            IMx:  o.flux_mom_x  = word_t'(lf);
            IMy:  o.flux_mom_y  = word_t'(lf);
            default: o.flux_energy = word_t'(lf);
          endcase
        end
      end
    end
    o.bad_density = bad;
    return o;
  endfunction

  // --- scoreboard ---
  out_word_t flux_q[$];
  int        n_err = 0;
  int        idle_cnt = 0;
  int        src_idle_pct = 0;
  int        snk_stall_pct = 0;
  int        hold_cycles = 0;

  // accepts happen at this edge; predict on input, compare on output
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) flux_q.push_back(model_flux(in_i));
      if (out_valid_o && out_ready_i) begin
        if (flux_q.size() == 0) begin
          $error("unexpected flux word %h", out_o);
          n_err++;
        end else begin
          out_word_t e;
          e = flux_q.pop_front();
          if (e.flux_mass !== out_o.flux_mass) begin
            $error("flux_mass exp %0d got %0d", e.flux_mass, out_o.flux_mass);
            n_err++;
          end
          if (e.flux_mom_x !== out_o.flux_mom_x) begin
            $error("flux_mom_x exp %0d got %0d", e.flux_mom_x, out_o.flux_mom_x);
            n_err++;
          end
          if (e.flux_mom_y !== out_o.flux_mom_y) begin
            $error("flux_mom_y exp %0d got %0d", e.flux_mom_y, out_o.flux_mom_y);
            n_err++;
          end
          if (e.flux_energy !== out_o.flux_energy) begin
            $error("flux_energy exp %0d got %0d", e.flux_energy, out_o.flux_energy);
            n_err++;
          end
          if (e.bad_density !== out_o.bad_density) begin
            $error("bad_density exp %0b got %0b", e.bad_density, out_o.bad_density);
            n_err++;
          end
        end
      end
    end
  end

  // watchdog: cycles with no word moving on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni)
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (idle_cnt > StallMax) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, or a long forced hold-off for backpressure
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // --- stimulus ---
  task automatic cfg_write(logic [RegIdxW-1:0] idx, logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      RegGamma: gam_q  = longint'(val);
      RegDtDx:  dtdx_q = longint'(val);
      RegDxDt:  dxdt_q = longint'(val);
      RegDtDy:  dtdy_q = longint'(val);
      RegDyDt:  dydt_q = longint'(val);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // block must be drained before registers change
  task automatic drain();
    in_valid_i <= 1'b0;
    while (flux_q.size() != 0) @(posedge clk_i);
    repeat (Settle) @(posedge clk_i);
  endtask

  // valid stays up between back-to-back words; drops only while idling
  task automatic send(in_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] rnd_mom(int scale);
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'sd0;
      default: return $signed($urandom_range(2 * scale)) - scale;
    endcase
  endfunction

  function automatic logic [30:0] rnd_pos(int scale);
    case ($urandom_range(9))
      0: return 31'($urandom());
      1: return 31'd0;
      default: return 31'($urandom_range(scale, 1));
    endcase
  endfunction

  // mostly physical states (density 2^-16..8, modest momentum), some noise
  function automatic in_word_t rnd_state();
    in_word_t w;
    w.req_type      = 1'($urandom_range(1));
    w.left_density  = rnd_pos(32'h8_0000);
    w.right_density = rnd_pos(32'h8_0000);
    w.left_mom_x    = rnd_mom(32'h4_0000);
    w.left_mom_y    = rnd_mom(32'h4_0000);
    w.right_mom_x   = rnd_mom(32'h4_0000);
    w.right_mom_y   = rnd_mom(32'h4_0000);
    w.left_energy   = rnd_pos(32'h20_0000);
    w.right_energy  = rnd_pos(32'h20_0000);
    return w;
  endfunction

  // directed rows: fields, plus flag for an at-a-glance expectation
  typedef struct {
    in_word_t  w;
    bit        has_exp;
    out_word_t e;
  } row_t;

  localparam logic [30:0] PMax = 31'h7FFF_FFFF;
  localparam out_word_t   BadZero = '{default: '0, bad_density: 1'b1};
  localparam out_word_t   Zeros   = '0;

  row_t dir_rows[$];

  initial begin
    in_word_t one;
    gam_q = longint'(GammaReset);
    dtdx_q = 0; dxdt_q = 0; dtdy_q = 0; dydt_q = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    one = '{1'b0, 31'h1_0000, 32'sd0, 32'sd0, 31'h0,
            31'h1_0000, 32'sd0, 32'sd0, 31'h0};
    // zero density left / right -> error flag, zero flux
    dir_rows.push_back('{'{1'b0, 31'd0, 32'sh7FFF_FFFF, -32'sd1, PMax,
                           31'h1_0000, 32'sd5, 32'sd5, 31'd5}, 1, BadZero});
    dir_rows.push_back('{'{1'b1, 31'h1_0000, -32'sh8000_0000, 32'sd7, 31'd3,
                           31'd0, 32'sd0, 32'sd0, 31'd0}, 1, BadZero});
    dir_rows.push_back('{'{1'b0, 31'd0, 32'sd0, 32'sd0, 31'd0,
                           31'd0, 32'sd0, 32'sd0, 31'd0}, 1, BadZero});
    // still gas, zero energy, zero steps: all fluxes zero
    dir_rows.push_back('{one, 1, Zeros});
    one.req_type = 1'b1;
    dir_rows.push_back('{one, 1, Zeros});
    // extremes, checked against the predictor
    dir_rows.push_back('{'{1'b0, PMax, 32'sh7FFF_FFFF, -32'sh8000_0000, PMax,
                           PMax, -32'sh8000_0000, 32'sh7FFF_FFFF, PMax}, 0, Zeros});
    dir_rows.push_back('{'{1'b1, PMax, -32'sh8000_0000, 32'sh7FFF_FFFF, PMax,
                           31'd1, 32'sh7FFF_FFFF, -32'sh8000_0000, 31'd0}, 0, Zeros});
    dir_rows.push_back('{'{1'b0, 31'd1, 32'sd1, 32'sd1, 31'd1,
                           31'd1, -32'sd1, -32'sd1, PMax}, 0, Zeros});
    dir_rows.push_back('{'{1'b1, 31'h1_0000, 32'sh1_8000, -32'sh2_0000, 31'h5_0000,
                           31'h2_0000, -32'sh1_0000, 32'sh8000, 31'h3_0000}, 0, Zeros});
    dir_rows.push_back('{'{1'b0, 31'h1_0000, 32'sh1_8000, -32'sh2_0000, 31'h5_0000,
                           31'h2_0000, -32'sh1_0000, 32'sh8000, 31'h3_0000}, 0, Zeros});

    // directed pass at reset config, then with large steps (half-step collapse)
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) begin
        cfg_write(RegDtDx, 31'h4_0000);
        cfg_write(RegDxDt, 31'h4000);
        cfg_write(RegDtDy, PMax);
        cfg_write(RegDyDt, PMax);
      end
      foreach (dir_rows[k]) begin
        send(dir_rows[k].w);
        if (dir_rows[k].has_exp && model_flux(dir_rows[k].w) !== dir_rows[k].e) begin
          $error("directed row %0d: predictor disagrees with table", k);
          n_err++;
        end
      end
      drain();
    end
    // large dt/dy: strongly converging y momenta saturate the half-step density
    send('{1'b1, 31'h1_0000, 32'sd0, 32'sh7FFF_0000, 31'h1_0000,
           31'h1_0000, 32'sd0, -32'sh7FFF_0000, 31'h1_0000});
    drain();

    // random phases: config and idling profile change between phases
    for (int ph = 0; ph < 7; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 73; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 73; end
        default: begin src_idle_pct = 30; snk_stall_pct = 30; end
      endcase
      case (ph)
        0: begin
          cfg_write(RegGamma, GammaReset);
          cfg_write(RegDtDx, 31'h1999); cfg_write(RegDxDt, 31'hA_0000);
          cfg_write(RegDtDy, 31'h1999); cfg_write(RegDyDt, 31'hA_0000);
        end
        1: begin
          cfg_write(RegGamma, 31'd0);
          cfg_write(RegDtDx, 31'd0); cfg_write(RegDxDt, 31'd0);
          cfg_write(RegDtDy, 31'd0); cfg_write(RegDyDt, 31'd0);
        end
        2: begin
          cfg_write(RegGamma, PMax);
          cfg_write(RegDtDx, PMax); cfg_write(RegDxDt, PMax);
          cfg_write(RegDtDy, PMax); cfg_write(RegDyDt, PMax);
        end
        default: begin
          cfg_write(RegGamma, 31'($urandom_range(32'h2_0000)));
          cfg_write(RegDtDx, 31'($urandom_range(32'h1_0000)));
          cfg_write(RegDxDt, 31'($urandom_range(32'h40_0000)));
          cfg_write(RegDtDy, 31'($urandom_range(32'h1_0000)));
          cfg_write(RegDyDt, 31'($urandom_range(32'h40_0000)));
          // unmapped index must be dropped
          cfg_write(RegIdxW'(5 + $urandom_range(2)), 31'($urandom()));
        end
      endcase
      // one long receiver hold-off while the sender keeps pushing
      if (ph == 0) hold_cycles = 3 * PipeLat;
      for (int n = 0; n < NumRand / 7; n++) send(rnd_state());
      drain();
    end

    if (n_err == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
